>>> rtl/core/wld_pkg.sv
// Shared constants, types and codes of the windowed lock-in detector.
`timescale 1ns / 1ps

package wld_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int TRIG_BITS   = 16;

  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = 32 + ADDR_W;
  localparam int WSUM_W = 15 + CNT_W;
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 64;
  localparam int DVD_W  = 64;
  localparam int DVS_W  = 32;
  localparam int IDX_W  = 4;
  localparam int RAM_W  = 64;
  localparam int MIN_SAMPLES = 4;

  localparam logic [31:0] TRIG_KEEP    = ~((32'd1 << (32 - TRIG_BITS)) - 32'd1);
  localparam logic [30:0] ONE_Q30      = 31'd1073741824;
  localparam logic [31:0] POLY_A       = 32'd1686629713;
  localparam logic [31:0] POLY_B       = 32'd688904866;
  localparam logic [31:0] POLY_C       = 32'd76016977;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] PHASE_STEP_RESET = 32'd267;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MEAN_GO, ST_MEAN_WAIT, ST_STEP_GO, ST_STEP_WAIT,
    ST_RD, ST_LOAD, ST_PH, ST_T0, ST_T1, ST_T2, ST_T3, ST_T4,
    ST_V, ST_VI, ST_VQ, ST_ACC,
    ST_AMPI_GO, ST_AMPI_WAIT, ST_AMPQ_GO, ST_AMPQ_WAIT,
    ST_SQI, ST_SQQ, ST_SQ_GO, ST_SQ_WAIT, ST_DONE
  } wld_state_t;

  typedef enum logic [1:0] {
    TRIG_WIN, TRIG_COS, TRIG_SIN
  } wld_trig_t;

  typedef enum logic [IDX_W-1:0] {
    REG_PHASE_STEP = 4'd0,
    REG_REF_TIME   = 4'd1
  } wld_reg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } wld_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } wld_div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } wld_sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } wld_sqrt_rsp_t;

endpackage

>>> rtl/core/wld_ifs.sv
// Handshake channel interfaces: sample input, result output and register writes.
`timescale 1ns / 1ps

interface wld_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic        [63:0] stamp;
  logic               last;
  modport source (output valid, output sample, output stamp, output last, input ready);
  modport sink   (input valid, input sample, input stamp, input last, output ready);
endinterface

interface wld_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] in_phase;
  logic signed [31:0] quadrature;
  logic        [30:0] magnitude;
  logic               short_capture;
  modport source (output valid, output in_phase, output quadrature, output magnitude,
                  output short_capture, input ready);
  modport sink   (input valid, input in_phase, input quadrature, input magnitude,
                  input short_capture, output ready);
endinterface

interface wld_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [wld_pkg::IDX_W-1:0]    index;
  logic [63:0]                  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/wld_ram.sv
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module wld_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/wld_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module wld_mul (
  input  logic                               clk,
  input  logic signed [wld_pkg::MUL_W-1:0]   a,
  input  logic signed [wld_pkg::MUL_W-1:0]   b,
  output logic signed [wld_pkg::PROD_W-1:0]  p
);

  logic signed [wld_pkg::PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

>>> rtl/core/wld_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module wld_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wld_pkg::wld_div_req_t req,
  output wld_pkg::wld_div_rsp_t rsp
);

  localparam int STEP_W = $clog2(wld_pkg::DVD_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(wld_pkg::DVD_W - 1);

  logic                        busy_r;
  logic                        done_r;
  logic [STEP_W-1:0]           step_r;
  logic [wld_pkg::DVD_W-1:0]   dvd_r;
  logic [wld_pkg::DVS_W-1:0]   dvs_r;
  logic [wld_pkg::DVS_W-1:0]   rem_r;
  logic [wld_pkg::DVS_W:0]     trial;
  logic [wld_pkg::DVS_W:0]     diff;
  logic                        fits;

  always_comb begin
    trial = {rem_r, dvd_r[wld_pkg::DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[wld_pkg::DVS_W-1:0] : trial[wld_pkg::DVS_W-1:0];
      dvd_r <= {dvd_r[wld_pkg::DVD_W-2:0], fits};
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dvd_r;
  assign rsp.remainder = rem_r;

endmodule

>>> rtl/core/wld_sqrt.sv
// Integer square root that settles one result bit per cycle.
`timescale 1ns / 1ps

module wld_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wld_pkg::wld_sqrt_req_t req,
  output wld_pkg::wld_sqrt_rsp_t rsp
);

  localparam logic [4:0] LAST_STEP = 5'd31;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  step_r;
  logic [63:0] v_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] trial;
  logic        fits;

  always_comb begin
    trial = res_r + bit_r;
    fits  = v_r >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 5'd1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      v_r   <= req.radicand;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      v_r   <= fits ? v_r - trial : v_r;
      res_r <= fits ? (res_r >> 1) + bit_r : res_r >> 1;
      bit_r <= bit_r >> 2;
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = res_r[31:0];

endmodule

>>> rtl/core/windowed_lockin_detector.sv
// Top level of the windowed lock-in detector: capture store, sequencer and datapath.
`timescale 1ns / 1ps
// Samples that do not close a capture are taken one per cycle.
// A closing sample starts a second pass with three sine evaluations per stored sample
// on the shared multiplier, followed by four divisions and a square root; a short
// capture goes straight to ST_DONE, which loads the result register once it is free.
// Reset (rst_n, synchronous, active low) empties the capture and restores the
// registers to their defaults; the sample store is not cleared and needs no pass.

module windowed_lockin_detector (
  input  logic      clk,
  input  logic      rst_n,
  wld_in_if.sink    in_chan,
  wld_out_if.source out_chan,
  wld_cfg_if.sink   cfg_chan
);

  // Configuration registers. Only the low word of the reference time matters,
  // because the reference phase is taken modulo one turn of a 32-bit product.
  logic [31:0] phase_step_r;
  logic [31:0] ref_lo_r;

  // Capture accumulation.
  logic [wld_pkg::CNT_W-1:0]        cnt_r;
  logic signed [wld_pkg::SUM_W-1:0] sum_r;

  wld_pkg::wld_state_t state_r, state_nxt;

  // Working registers of the second pass.
  logic [wld_pkg::CNT_W-1:0]         n_r, n_nxt;
  logic [wld_pkg::CNT_W-1:0]         d_r, d_nxt;
  logic signed [wld_pkg::SUM_W-1:0]  tsum_r, tsum_nxt;
  logic signed [31:0]                mean_r, mean_nxt;
  logic [31:0]                       step_r, step_nxt;
  logic [wld_pkg::CNT_W-1:0]         srem_r, srem_nxt;
  logic [wld_pkg::CNT_W-1:0]         idx_r, idx_nxt;
  logic [31:0]                       wph_r, wph_nxt;
  logic [wld_pkg::CNT_W-1:0]         wacc_r, wacc_nxt;
  logic signed [31:0]                smp_r, smp_nxt;
  logic [31:0]                       rph_r, rph_nxt;
  logic [31:0]                       trig_p_r, trig_p_nxt;
  wld_pkg::wld_trig_t                trig_sel_r, trig_sel_nxt;
  logic [1:0]                        quad_r, quad_nxt;
  logic [30:0]                       x_r, x_nxt;
  logic [30:0]                       x2_r, x2_nxt;
  logic [14:0]                       win_r, win_nxt;
  logic signed [15:0]                cos_r, cos_nxt;
  logic signed [15:0]                sin_r, sin_nxt;
  logic signed [32:0]                v_r, v_nxt;
  logic signed [wld_pkg::ACC_W-1:0]  acc_i_r, acc_i_nxt;
  logic signed [wld_pkg::ACC_W-1:0]  acc_q_r, acc_q_nxt;
  logic [wld_pkg::WSUM_W-1:0]        wsum_r, wsum_nxt;
  logic signed [31:0]                oi_r, oi_nxt;
  logic signed [31:0]                oq_r, oq_nxt;
  logic [63:0]                       sq_r, sq_nxt;
  logic [30:0]                       mag_r, mag_nxt;
  logic                              short_r, short_nxt;

  // Result register towards the output channel.
  logic               out_valid_r;
  logic signed [31:0] out_i_r;
  logic signed [31:0] out_q_r;
  logic [30:0]        out_mag_r;
  logic               out_short_r;

  // Shared units.
  logic signed [wld_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [wld_pkg::PROD_W-1:0] mul_p;
  wld_pkg::wld_div_req_t             div_req;
  wld_pkg::wld_div_rsp_t             div_rsp;
  wld_pkg::wld_sqrt_req_t            sqrt_req;
  wld_pkg::wld_sqrt_rsp_t            sqrt_rsp;

  logic                       ram_we;
  logic [wld_pkg::RAM_W-1:0]  ram_wdata;
  logic [wld_pkg::RAM_W-1:0]  ram_rdata;

  // Input side.
  logic                              in_acc;
  logic                              store_ok;
  logic [wld_pkg::CNT_W-1:0]         cnt_after;
  logic signed [wld_pkg::SUM_W-1:0]  sum_after;
  logic                              out_load;

  // Sine evaluation and other datapath terms.
  logic [31:0]        tq;
  logic [30:0]        tx;
  logic [31:0]        poly_t;
  logic [32:0]        rnd;
  logic [17:0]        rmag;
  logic [14:0]        mag15;
  logic signed [15:0] trig_val;
  logic signed [16:0] w17;
  logic signed [32:0] diff;
  logic [wld_pkg::SUM_W-1:0] tsum_abs;
  logic signed [wld_pkg::ACC_W-1:0] amp_acc;
  logic [wld_pkg::ACC_W-1:0]        amp_abs;
  logic signed [31:0]               amp_val;
  logic [wld_pkg::CNT_W:0]          wacc_sum;
  logic [wld_pkg::DVS_W-1:0]        wsum_eff;

  assign in_chan.ready  = (state_r == wld_pkg::ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign store_ok       = cnt_r < wld_pkg::CNT_W'(wld_pkg::MAX_SAMPLES);
  assign cnt_after      = store_ok ? cnt_r + wld_pkg::CNT_W'(1) : cnt_r;
  assign sum_after      = store_ok ? sum_r + wld_pkg::SUM_W'(in_chan.sample) : sum_r;
  assign out_load       = (state_r == wld_pkg::ST_DONE) && (!out_valid_r || out_chan.ready);

  // Each stored entry holds the sample above the low word of its time stamp.
  assign ram_we    = in_acc && store_ok;
  assign ram_wdata = {in_chan.sample, in_chan.stamp[31:0]};

  wld_ram #(
    .WIDTH (wld_pkg::RAM_W),
    .DEPTH (wld_pkg::MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[wld_pkg::ADDR_W-1:0]),
    .wdata (ram_wdata),
    .raddr (idx_r[wld_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  wld_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  wld_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  wld_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  // Sine of trig_p_r: the quadrant is folded onto a quarter turn, an odd polynomial
  // in x is worked out over four multiplications, and the result is rounded to Q1.15.
  always_comb begin
    tq       = trig_p_r & wld_pkg::TRIG_KEEP;
    tx       = tq[30] ? wld_pkg::ONE_Q30 - {1'b0, tq[29:0]} : {1'b0, tq[29:0]};
    poly_t   = (state_r == wld_pkg::ST_T2) ? wld_pkg::POLY_B - mul_p[61:30]
                                           : wld_pkg::POLY_A - mul_p[61:30];
    rnd      = {1'b0, mul_p[61:30]} + 33'd16384;
    rmag     = rnd[32:15];
    mag15    = (rmag > 18'd32767) ? 15'h7FFF : rmag[14:0];
    trig_val = quad_r[1] ? -$signed({1'b0, mag15}) : $signed({1'b0, mag15});
    // Hann weight: half of one minus the cosine, in unsigned Q0.15.
    w17      = 17'sh08000 - {trig_val[15], trig_val};
    diff     = {smp_r[31], smp_r} - {mean_r[31], mean_r};
    tsum_abs = tsum_r[wld_pkg::SUM_W-1] ? wld_pkg::SUM_W'(-tsum_r) : wld_pkg::SUM_W'(tsum_r);
    wacc_sum = {1'b0, wacc_r} + {1'b0, srem_r};
    wsum_eff = (wsum_r == '0) ? wld_pkg::DVS_W'(1) : wld_pkg::DVS_W'(wsum_r);
  end

  // Amplitude: twice the weighted sum over the window sum, saturated to 32 bits.
  always_comb begin
    amp_acc = (state_r == wld_pkg::ST_AMPI_GO || state_r == wld_pkg::ST_AMPI_WAIT)
              ? acc_i_r : acc_q_r;
    amp_abs = amp_acc[wld_pkg::ACC_W-1] ? wld_pkg::ACC_W'(-amp_acc) : wld_pkg::ACC_W'(amp_acc);
    if (amp_acc[wld_pkg::ACC_W-1]) begin
      if (div_rsp.quotient > wld_pkg::DVD_W'(64'h8000_0000)) begin
        amp_val = 32'sh8000_0000;
      end else begin
        amp_val = -$signed(div_rsp.quotient[31:0]);
      end
    end else begin
      if (div_rsp.quotient > wld_pkg::DVD_W'(64'h7FFF_FFFF)) begin
        amp_val = 32'sh7FFF_FFFF;
      end else begin
        amp_val = $signed(div_rsp.quotient[31:0]);
      end
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wld_pkg::ST_IDLE: begin
        if (in_acc && in_chan.last) begin
          state_nxt = (cnt_after < wld_pkg::CNT_W'(wld_pkg::MIN_SAMPLES))
                      ? wld_pkg::ST_DONE : wld_pkg::ST_MEAN_GO;
        end
      end
      wld_pkg::ST_MEAN_GO:   state_nxt = wld_pkg::ST_MEAN_WAIT;
      wld_pkg::ST_MEAN_WAIT: if (div_rsp.done) state_nxt = wld_pkg::ST_STEP_GO;
      wld_pkg::ST_STEP_GO:   state_nxt = wld_pkg::ST_STEP_WAIT;
      wld_pkg::ST_STEP_WAIT: if (div_rsp.done) state_nxt = wld_pkg::ST_RD;
      wld_pkg::ST_RD:        state_nxt = wld_pkg::ST_LOAD;
      wld_pkg::ST_LOAD:      state_nxt = wld_pkg::ST_PH;
      wld_pkg::ST_PH:        state_nxt = wld_pkg::ST_T0;
      wld_pkg::ST_T0:        state_nxt = wld_pkg::ST_T1;
      wld_pkg::ST_T1:        state_nxt = wld_pkg::ST_T2;
      wld_pkg::ST_T2:        state_nxt = wld_pkg::ST_T3;
      wld_pkg::ST_T3:        state_nxt = wld_pkg::ST_T4;
      wld_pkg::ST_T4: begin
        state_nxt = (trig_sel_r == wld_pkg::TRIG_SIN) ? wld_pkg::ST_V : wld_pkg::ST_T0;
      end
      wld_pkg::ST_V:         state_nxt = wld_pkg::ST_VI;
      wld_pkg::ST_VI:        state_nxt = wld_pkg::ST_VQ;
      wld_pkg::ST_VQ:        state_nxt = wld_pkg::ST_ACC;
      wld_pkg::ST_ACC: begin
        state_nxt = (idx_r == d_r) ? wld_pkg::ST_AMPI_GO : wld_pkg::ST_RD;
      end
      wld_pkg::ST_AMPI_GO:   state_nxt = wld_pkg::ST_AMPI_WAIT;
      wld_pkg::ST_AMPI_WAIT: if (div_rsp.done) state_nxt = wld_pkg::ST_AMPQ_GO;
      wld_pkg::ST_AMPQ_GO:   state_nxt = wld_pkg::ST_AMPQ_WAIT;
      wld_pkg::ST_AMPQ_WAIT: if (div_rsp.done) state_nxt = wld_pkg::ST_SQI;
      wld_pkg::ST_SQI:       state_nxt = wld_pkg::ST_SQQ;
      wld_pkg::ST_SQQ:       state_nxt = wld_pkg::ST_SQ_GO;
      wld_pkg::ST_SQ_GO:     state_nxt = wld_pkg::ST_SQ_WAIT;
      wld_pkg::ST_SQ_WAIT:   if (sqrt_rsp.done) state_nxt = wld_pkg::ST_DONE;
      wld_pkg::ST_DONE:      if (out_load) state_nxt = wld_pkg::ST_IDLE;
      default:               state_nxt = wld_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: datapath controls, operand selection and working register updates.
  always_comb begin
    n_nxt        = n_r;
    d_nxt        = d_r;
    tsum_nxt     = tsum_r;
    mean_nxt     = mean_r;
    step_nxt     = step_r;
    srem_nxt     = srem_r;
    idx_nxt      = idx_r;
    wph_nxt      = wph_r;
    wacc_nxt     = wacc_r;
    smp_nxt      = smp_r;
    rph_nxt      = rph_r;
    trig_p_nxt   = trig_p_r;
    trig_sel_nxt = trig_sel_r;
    quad_nxt     = quad_r;
    x_nxt        = x_r;
    x2_nxt       = x2_r;
    win_nxt      = win_r;
    cos_nxt      = cos_r;
    sin_nxt      = sin_r;
    v_nxt        = v_r;
    acc_i_nxt    = acc_i_r;
    acc_q_nxt    = acc_q_r;
    wsum_nxt     = wsum_r;
    oi_nxt       = oi_r;
    oq_nxt       = oq_r;
    sq_nxt       = sq_r;
    mag_nxt      = mag_r;
    short_nxt    = short_r;
    mul_a        = '0;
    mul_b        = '0;
    div_req      = '0;
    sqrt_req     = '0;

    case (state_r)
      wld_pkg::ST_IDLE: begin
        if (in_acc && in_chan.last) begin
          n_nxt     = cnt_after;
          tsum_nxt  = sum_after;
          short_nxt = cnt_after < wld_pkg::CNT_W'(wld_pkg::MIN_SAMPLES);
          oi_nxt    = '0;
          oq_nxt    = '0;
          mag_nxt   = '0;
        end
      end
      wld_pkg::ST_MEAN_GO: begin
        d_nxt            = n_r - wld_pkg::CNT_W'(1);
        div_req.start    = 1'b1;
        div_req.dividend = wld_pkg::DVD_W'(tsum_abs);
        div_req.divisor  = wld_pkg::DVS_W'(n_r);
      end
      wld_pkg::ST_MEAN_WAIT: begin
        if (div_rsp.done) begin
          mean_nxt = tsum_r[wld_pkg::SUM_W-1] ? -$signed(div_rsp.quotient[31:0])
                                              : $signed(div_rsp.quotient[31:0]);
        end
      end
      wld_pkg::ST_STEP_GO: begin
        // Window phase advances by one turn over (n - 1) samples.
        div_req.start    = 1'b1;
        div_req.dividend = wld_pkg::DVD_W'(64'h1_0000_0000);
        div_req.divisor  = wld_pkg::DVS_W'(d_r);
      end
      wld_pkg::ST_STEP_WAIT: begin
        if (div_rsp.done) begin
          step_nxt  = div_rsp.quotient[31:0];
          srem_nxt  = div_rsp.remainder[wld_pkg::CNT_W-1:0];
          idx_nxt   = '0;
          wph_nxt   = '0;
          wacc_nxt  = '0;
          acc_i_nxt = '0;
          acc_q_nxt = '0;
          wsum_nxt  = '0;
        end
      end
      wld_pkg::ST_LOAD: begin
        smp_nxt = $signed(ram_rdata[63:32]);
        mul_a   = {2'b00, ram_rdata[31:0] - ref_lo_r};
        mul_b   = {2'b00, phase_step_r};
      end
      wld_pkg::ST_PH: begin
        rph_nxt      = mul_p[31:0];
        trig_p_nxt   = wph_r + wld_pkg::QUARTER_TURN;
        trig_sel_nxt = wld_pkg::TRIG_WIN;
      end
      wld_pkg::ST_T0: begin
        quad_nxt = tq[31:30];
        x_nxt    = tx;
        mul_a    = {3'b000, tx};
        mul_b    = {3'b000, tx};
      end
      wld_pkg::ST_T1: begin
        x2_nxt = mul_p[60:30];
        mul_a  = {3'b000, mul_p[60:30]};
        mul_b  = {2'b00, wld_pkg::POLY_C};
      end
      wld_pkg::ST_T2: begin
        mul_a = {3'b000, x2_r};
        mul_b = {2'b00, poly_t};
      end
      wld_pkg::ST_T3: begin
        mul_a = {3'b000, x_r};
        mul_b = {2'b00, poly_t};
      end
      wld_pkg::ST_T4: begin
        case (trig_sel_r)
          wld_pkg::TRIG_WIN: begin
            win_nxt      = w17[15:1];
            trig_p_nxt   = rph_r + wld_pkg::QUARTER_TURN;
            trig_sel_nxt = wld_pkg::TRIG_COS;
          end
          wld_pkg::TRIG_COS: begin
            cos_nxt      = trig_val;
            trig_p_nxt   = rph_r;
            trig_sel_nxt = wld_pkg::TRIG_SIN;
          end
          wld_pkg::TRIG_SIN: begin
            sin_nxt = trig_val;
          end
          default: begin
            trig_sel_nxt = wld_pkg::TRIG_SIN;
          end
        endcase
      end
      wld_pkg::ST_V: begin
        mul_a = {diff[32], diff};
        mul_b = {19'd0, win_r};
      end
      wld_pkg::ST_VI: begin
        v_nxt = $signed(mul_p[47:15]);
        mul_a = {mul_p[47], mul_p[47:15]};
        mul_b = {{18{cos_r[15]}}, cos_r};
      end
      wld_pkg::ST_VQ: begin
        acc_i_nxt = acc_i_r + $signed(mul_p[wld_pkg::ACC_W-1:0]);
        mul_a     = {v_r[32], v_r};
        mul_b     = {{18{sin_r[15]}}, sin_r};
      end
      wld_pkg::ST_ACC: begin
        acc_q_nxt = acc_q_r + $signed(mul_p[wld_pkg::ACC_W-1:0]);
        wsum_nxt  = wsum_r + wld_pkg::WSUM_W'(win_r);
        idx_nxt   = idx_r + wld_pkg::CNT_W'(1);
        if (wacc_sum >= {1'b0, d_r}) begin
          wph_nxt  = wph_r + step_r + 32'd1;
          wacc_nxt = wld_pkg::CNT_W'(wacc_sum - {1'b0, d_r});
        end else begin
          wph_nxt  = wph_r + step_r;
          wacc_nxt = wacc_sum[wld_pkg::CNT_W-1:0];
        end
      end
      wld_pkg::ST_AMPI_GO, wld_pkg::ST_AMPQ_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {amp_abs[wld_pkg::ACC_W-2:0], 1'b0};
        div_req.divisor  = wsum_eff;
      end
      wld_pkg::ST_AMPI_WAIT: begin
        if (div_rsp.done) begin
          oi_nxt = amp_val;
        end
      end
      wld_pkg::ST_AMPQ_WAIT: begin
        if (div_rsp.done) begin
          oq_nxt = amp_val;
        end
      end
      wld_pkg::ST_SQI: begin
        mul_a = {{2{oi_r[31]}}, oi_r};
        mul_b = {{2{oi_r[31]}}, oi_r};
      end
      wld_pkg::ST_SQQ: begin
        sq_nxt = mul_p[63:0];
        mul_a  = {{2{oq_r[31]}}, oq_r};
        mul_b  = {{2{oq_r[31]}}, oq_r};
      end
      wld_pkg::ST_SQ_GO: begin
        sqrt_req.start    = 1'b1;
        sqrt_req.radicand = sq_r + mul_p[63:0];
      end
      wld_pkg::ST_SQ_WAIT: begin
        if (sqrt_rsp.done) begin
          mag_nxt = sqrt_rsp.root[31] ? 31'h7FFF_FFFF : sqrt_rsp.root[30:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wld_pkg::ST_IDLE;
      cnt_r        <= '0;
      sum_r        <= '0;
      phase_step_r <= wld_pkg::PHASE_STEP_RESET;
      ref_lo_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (in_chan.last) begin
          cnt_r <= '0;
          sum_r <= '0;
        end else begin
          cnt_r <= cnt_after;
          sum_r <= sum_after;
        end
      end
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          wld_pkg::REG_PHASE_STEP: phase_step_r <= cfg_chan.data[31:0];
          wld_pkg::REG_REF_TIME:   ref_lo_r     <= cfg_chan.data[31:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    tsum_r     <= tsum_nxt;
    mean_r     <= mean_nxt;
    step_r     <= step_nxt;
    srem_r     <= srem_nxt;
    idx_r      <= idx_nxt;
    wph_r      <= wph_nxt;
    wacc_r     <= wacc_nxt;
    smp_r      <= smp_nxt;
    rph_r      <= rph_nxt;
    trig_p_r   <= trig_p_nxt;
    trig_sel_r <= trig_sel_nxt;
    quad_r     <= quad_nxt;
    x_r        <= x_nxt;
    x2_r       <= x2_nxt;
    win_r      <= win_nxt;
    cos_r      <= cos_nxt;
    sin_r      <= sin_nxt;
    v_r        <= v_nxt;
    acc_i_r    <= acc_i_nxt;
    acc_q_r    <= acc_q_nxt;
    wsum_r     <= wsum_nxt;
    oi_r       <= oi_nxt;
    oq_r       <= oq_nxt;
    sq_r       <= sq_nxt;
    mag_r      <= mag_nxt;
    short_r    <= short_nxt;
    if (out_load) begin
      out_i_r     <= oi_r;
      out_q_r     <= oq_r;
      out_mag_r   <= mag_r;
      out_short_r <= short_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.in_phase      = out_i_r;
  assign out_chan.quadrature    = out_q_r;
  assign out_chan.magnitude     = out_mag_r;
  assign out_chan.short_capture = out_short_r;

endmodule

>>> rtl/core/wld_chk.sv
// Port-level assertions for the windowed lock-in detector and their binding.
`timescale 1ns / 1ps

module wld_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_last,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_in_phase,
  input logic signed [31:0] out_quadrature,
  input logic [30:0]        out_magnitude,
  input logic               out_short
);

  // A pending result stays valid, with its in-phase value stable, until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_in_phase))
    else $error("result changed or vanished while stalled");

  // A short capture reports zero amplitudes.
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_short |-> out_in_phase == 0 && out_quadrature == 0
                               && out_magnitude == 0)
    else $error("short capture with non-zero amplitude");

  // Closing a capture makes the block busy.
  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still ready after the closing transaction");

  // Samples inside a capture are taken back to back.
  a_open_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last |=> in_ready)
    else $error("input not ready after a non-closing transaction");

endmodule

bind windowed_lockin_detector wld_chk u_wld_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_last        (in_chan.last),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_in_phase   (out_chan.in_phase),
  .out_quadrature (out_chan.quadrature),
  .out_magnitude  (out_chan.magnitude),
  .out_short      (out_chan.short_capture)
);
